// ----- sv/cbb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cbb_pkg;

	localparam int CW  = 32;             // coordinate width
	localparam int PF  = 16;             // fraction bits of the curve parameter
	localparam int TW  = PF + 1;         // parameter width, reaches 1.0
	localparam int AW  = CW + 4;         // derivative coefficient width
	localparam int HW  = (AW + 1) / 2;   // half width for split multiplies
	localparam int MW  = 2 * HW;
	localparam int DSW = 2 * MW + 4;     // discriminant width
	localparam int ATW = AW + PF + 1;    // a*T
	localparam int DW  = AW + PF + 2;    // q'(T) scaled
	localparam int QW  = AW + 2 * PF + 2; // q(T) scaled
	localparam int NS  = PF + 9;         // pipeline depth

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [AW-1:0] coef_t;
	typedef logic signed [AW:0]   wcoef_t;
	typedef logic [TW-1:0]        tpar_t;

	localparam tpar_t T_ONE = {1'b1, {PF{1'b0}}};

	typedef enum logic [1:0] {PK_LOW, PK_HIGH, PK_LIN, PK_VERTEX} kind_t;

	typedef struct packed {
		coord_t p0;
		coord_t p1;
		coord_t p2;
		coord_t p3;
	} pts_t;

	// one root search: bits of T found so far, with q(T), a*T and q'(T) kept exact
	typedef struct packed {
		kind_t                 kind;
		logic                  full;
		logic [PF-1:0]         t;
		logic signed [QW-1:0]  q;
		logic signed [ATW-1:0] at;
		logic signed [DW-1:0]  d;
	} chain_t;

	typedef struct packed {
		pts_t   p;
		logic   on;
		coef_t  a;
		coef_t  b;
		chain_t c0;
		chain_t c1;
	} srch_t;

	typedef struct packed {
		coord_t v0;
		coord_t v1;
		coord_t v2;
		coord_t v3;
	} vals_t;

	function automatic logic pred(input kind_t kind, input logic q_neg, input logic q_zero,
			input logic d_neg, input logic d_zero);
		logic r;
		unique case (kind)
			PK_LOW:    r = !q_neg && (d_neg || d_zero);
			PK_HIGH:   r = d_neg || d_zero || q_neg || q_zero;
			PK_LIN:    r = q_neg || q_zero;
			PK_VERTEX: r = d_neg || d_zero;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/cbb_setup.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cbb_setup import cbb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  [2:0] en,
	input  wire pts_t  pts,
	output srch_t      srch
);

	pts_t          pts_s1, pts_s2;
	coef_t         a_s1, b_s1, c_s1;
	logic          str_s1, str_s2;
	coef_t         an_s2, bn_s2, cn_s2;
	logic          az_s2, bz_s2;
	wcoef_t        q1_s2, b2a_s2;
	logic [MW-1:0] bb_hh_s2, bb_hl_s2, bb_ll_s2;
	logic [MW-1:0] ac_hh_s2, ac_hl_s2, ac_lh_s2, ac_ll_s2;

	coef_t  d12, a_d, b_d, c_d;
	coef_t  an_d, bn_d, cn_d;
	logic   neg;
	logic [AW-1:0] bm_a, cm_a;
	logic [MW-1:0] am, bm, cm;
	logic [DSW-1:0] bsq, ac;
	logic signed [DSW-1:0] disc;
	logic   ds_neg, ds_zero, in0, in1;
	srch_t  srch_d;

	// derivative coefficients
	always_comb begin
		d12 = AW'(pts.p1) - AW'(pts.p2);
		a_d = (d12 <<< 1) + d12 + AW'(pts.p3) - AW'(pts.p0);
		b_d = (AW'(pts.p2) - (AW'(pts.p1) <<< 1) + AW'(pts.p0)) <<< 1;
		c_d = AW'(pts.p1) - AW'(pts.p0);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pts_s1 <= pts;
			a_s1   <= a_d;
			b_s1   <= b_d;
			c_s1   <= c_d;
			str_s1 <= (pts.p1 == pts.p2) && (pts.p2 == pts.p3);
		end
	end

	// make the leading coefficient nonnegative, split magnitudes for b^2 and a*c
	always_comb begin
		neg  = (a_s1 == '0) ? b_s1[AW-1] : a_s1[AW-1];
		an_d = neg ? -a_s1 : a_s1;
		bn_d = neg ? -b_s1 : b_s1;
		cn_d = neg ? -c_s1 : c_s1;
		bm_a = bn_d[AW-1] ? AW'(-bn_d) : AW'(bn_d);
		cm_a = cn_d[AW-1] ? AW'(-cn_d) : AW'(cn_d);
		am   = MW'($unsigned(an_d));
		bm   = MW'(bm_a);
		cm   = MW'(cm_a);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pts_s2   <= pts_s1;
			str_s2   <= str_s1;
			an_s2    <= an_d;
			bn_s2    <= bn_d;
			cn_s2    <= cn_d;
			az_s2    <= (a_s1 == '0);
			bz_s2    <= (b_s1 == '0);
			q1_s2    <= wcoef_t'(an_d) + wcoef_t'(bn_d) + wcoef_t'(cn_d);
			b2a_s2   <= (wcoef_t'(an_d) <<< 1) + wcoef_t'(bn_d);
			bb_hh_s2 <= bm[MW-1:HW] * bm[MW-1:HW];
			bb_hl_s2 <= bm[MW-1:HW] * bm[HW-1:0];
			bb_ll_s2 <= bm[HW-1:0] * bm[HW-1:0];
			ac_hh_s2 <= am[MW-1:HW] * cm[MW-1:HW];
			ac_hl_s2 <= am[MW-1:HW] * cm[HW-1:0];
			ac_lh_s2 <= am[HW-1:0] * cm[MW-1:HW];
			ac_ll_s2 <= am[HW-1:0] * cm[HW-1:0];
		end
	end

	// discriminant sign, root case, search setup at T = 0 and check of T = 1
	always_comb begin
		bsq = (DSW'(bb_hh_s2) << (2 * HW)) + (DSW'(bb_hl_s2) << (HW + 1)) + DSW'(bb_ll_s2);
		ac  = (DSW'(ac_hh_s2) << (2 * HW)) + ((DSW'(ac_hl_s2) + DSW'(ac_lh_s2)) << HW)
			+ DSW'(ac_ll_s2);
		disc    = cn_s2[AW-1] ? $signed(bsq + (ac << 2)) : $signed(bsq - (ac << 2));
		ds_neg  = disc[DSW-1];
		ds_zero = (disc == '0);
		in0 = (!cn_s2[AW-1] && bn_s2[AW-1]) && (q1_s2[AW] || q1_s2 == '0 || !b2a_s2[AW]
			&& b2a_s2 != '0);
		in1 = (cn_s2[AW-1] || cn_s2 == '0 || bn_s2[AW-1]) && (!q1_s2[AW]
			&& !b2a_s2[AW] && b2a_s2 != '0);

		srch_d.p  = pts_s2;
		srch_d.a  = an_s2;
		srch_d.b  = bn_s2;
		srch_d.on = 1'b0;
		srch_d.c0.kind = PK_LOW;
		srch_d.c1.kind = PK_LOW;
		priority if (str_s2 || (az_s2 && bz_s2)) begin
			srch_d.on = 1'b0;
		end else if (az_s2) begin
			srch_d.on = 1'b1;
			srch_d.c0.kind = PK_LIN;
			srch_d.c1.kind = PK_LIN;
		end else if (ds_neg) begin
			srch_d.on = 1'b0;
		end else if (ds_zero) begin
			srch_d.on = (bn_s2[AW-1] || bn_s2 == '0) && !b2a_s2[AW];
			srch_d.c0.kind = PK_VERTEX;
			srch_d.c1.kind = PK_VERTEX;
		end else begin
			srch_d.on = in0 || in1;
			srch_d.c0.kind = in0 ? PK_LOW : PK_HIGH;
			srch_d.c1.kind = in1 ? PK_HIGH : PK_LOW;
		end

		srch_d.c0.t  = '0;
		srch_d.c0.q  = QW'(cn_s2) <<< (2 * PF);
		srch_d.c0.at = '0;
		srch_d.c0.d  = DW'(bn_s2) <<< PF;
		srch_d.c1.t  = '0;
		srch_d.c1.q  = QW'(cn_s2) <<< (2 * PF);
		srch_d.c1.at = '0;
		srch_d.c1.d  = DW'(bn_s2) <<< PF;
		srch_d.c0.full = pred(srch_d.c0.kind, q1_s2[AW], q1_s2 == '0, b2a_s2[AW],
			b2a_s2 == '0);
		srch_d.c1.full = pred(srch_d.c1.kind, q1_s2[AW], q1_s2 == '0, b2a_s2[AW],
			b2a_s2 == '0);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			srch <= srch_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/cbb_search.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cbb_search import cbb_pkg::*; (
	input  wire logic   clk,
	input  wire logic   [PF-1:0] en,
	input  wire srch_t  srch_in,
	output srch_t       srch_out
);

	srch_t stg_s [PF:1];

	// try setting bit k of T; q, a*T and q' move by shifted adds only
	function automatic chain_t step(input chain_t ci, input coef_t a, input coef_t b,
			input int k);
		chain_t co;
		logic signed [QW-1:0]  qc;
		logic signed [ATW-1:0] atc;
		logic signed [DW-1:0]  dc;
		qc  = ci.q + ((((QW'(ci.at)) <<< 1) + (QW'(a) <<< k)) <<< k) + (QW'(b) <<< (k + PF));
		atc = ci.at + (ATW'(a) <<< k);
		dc  = ci.d + (DW'(a) <<< (k + 1));
		co  = ci;
		if (pred(ci.kind, qc[QW-1], qc == '0, dc[DW-1], dc == '0)) begin
			co.t[k] = 1'b1;
			co.q    = qc;
			co.at   = atc;
			co.d    = dc;
		end
		return co;
	endfunction

	for (genvar j = 1; j <= PF; j++) begin : g_bit
		srch_t prev, nxt;

		if (j == 1) begin : g_first
			assign prev = srch_in;
		end else begin : g_rest
			assign prev = stg_s[j-1];
		end

		always_comb begin
			nxt    = prev;
			nxt.c0 = step(prev.c0, prev.a, prev.b, PF - j);
			nxt.c1 = step(prev.c1, prev.a, prev.b, PF - j);
		end

		always_ff @(posedge clk) begin
			if (en[j-1]) begin
				stg_s[j] <= nxt;
			end
		end
	end

	assign srch_out = stg_s[PF];

endmodule

`default_nettype wire

// ----- sv/cbb_eval.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cbb_eval import cbb_pkg::*; (
	input  wire logic   clk,
	input  wire logic   [3:0] en,
	input  wire srch_t  srch,
	output vals_t       vals
);

	pts_t   pts_s1;
	tpar_t  t_s1 [2];
	tpar_t  t_s2 [2];
	tpar_t  t_s3 [2];
	coord_t q_s2 [2][3];
	coord_t r_s3 [2][2];
	coord_t e_s4 [2];
	coord_t p0_s2, p3_s2, p0_s3, p3_s3, p0_s4, p3_s4;

	// u + floor((v - u) * t), always between u and v
	function automatic coord_t lerp(input coord_t u, input coord_t v, input tpar_t t);
		logic signed [CW:0]      df;
		logic signed [CW+PF+2:0] prod;
		df   = (CW+1)'(v) - (CW+1)'(u);
		prod = df * $signed({1'b0, t});
		return u + CW'(prod >>> PF);
	endfunction

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pts_s1  <= srch.p;
			t_s1[0] <= !srch.on ? '0 : (srch.c0.full ? T_ONE : {1'b0, srch.c0.t});
			t_s1[1] <= !srch.on ? T_ONE : (srch.c1.full ? T_ONE : {1'b0, srch.c1.t});
		end
		if (en[1]) begin
			p0_s2 <= pts_s1.p0;
			p3_s2 <= pts_s1.p3;
			for (int i = 0; i < 2; i++) begin
				t_s2[i]    <= t_s1[i];
				q_s2[i][0] <= lerp(pts_s1.p0, pts_s1.p1, t_s1[i]);
				q_s2[i][1] <= lerp(pts_s1.p1, pts_s1.p2, t_s1[i]);
				q_s2[i][2] <= lerp(pts_s1.p2, pts_s1.p3, t_s1[i]);
			end
		end
		if (en[2]) begin
			p0_s3 <= p0_s2;
			p3_s3 <= p3_s2;
			for (int i = 0; i < 2; i++) begin
				t_s3[i]    <= t_s2[i];
				r_s3[i][0] <= lerp(q_s2[i][0], q_s2[i][1], t_s2[i]);
				r_s3[i][1] <= lerp(q_s2[i][1], q_s2[i][2], t_s2[i]);
			end
		end
		if (en[3]) begin
			p0_s4 <= p0_s3;
			p3_s4 <= p3_s3;
			for (int i = 0; i < 2; i++) begin
				e_s4[i] <= lerp(r_s3[i][0], r_s3[i][1], t_s3[i]);
			end
		end
	end

	assign vals = '{v0: p0_s4, v1: p3_s4, v2: e_s4[0], v3: e_s4[1]};

endmodule

`default_nettype wire

// ----- sv/cbb_range.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cbb_range import cbb_pkg::*; (
	input  wire logic   clk,
	input  wire logic   [1:0] en,
	input  wire vals_t  vals,
	output coord_t      lo,
	output logic [CW-1:0] span
);

	coord_t mn_s1, mx_s1;
	coord_t lo_s2;
	logic [CW-1:0] span_s2;
	coord_t mn_a, mn_b, mx_a, mx_b;

	always_comb begin
		mn_a = (vals.v1 < vals.v0) ? vals.v1 : vals.v0;
		mn_b = (vals.v3 < vals.v2) ? vals.v3 : vals.v2;
		mx_a = (vals.v1 > vals.v0) ? vals.v1 : vals.v0;
		mx_b = (vals.v3 > vals.v2) ? vals.v3 : vals.v2;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mn_s1 <= (mn_b < mn_a) ? mn_b : mn_a;
			mx_s1 <= (mx_b > mx_a) ? mx_b : mx_a;
		end
		if (en[1]) begin
			lo_s2   <= mn_s1;
			span_s2 <= CW'(mx_s1 - mn_s1);
		end
	end

	assign lo   = lo_s2;
	assign span = span_s2;

endmodule

`default_nettype wire

// ----- sv/cubic_bezier_bounding_box_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Bounding box of a cubic Bezier curve, Q16.16 coordinates.
// Input channel: in_valid/in_ready, one beat carries the four control points.
// Output channel: out_valid/out_ready, one beat carries left, top, width, height.
// Beats are taken every cycle while in_ready is high; results leave in input
// order, one per curve. Pipeline: 3 setup stages for the derivative
// coefficients and discriminant, 16 stages of a bit-per-stage root search,
// 4 evaluation stages, 2 min/max stages.
// Throughput: one curve per cycle while out_ready is high.
// When the receiver stalls, stages fill up behind the held result; in_ready
// stays high until every stage holds a beat, so bubbles are squeezed out.
// Reset clears all stage valid flags; no result is pending after reset.
module cubic_bezier_bounding_box_core import cbb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire coord_t start_x,
	input  wire coord_t start_y,
	input  wire coord_t ctrl1_x,
	input  wire coord_t ctrl1_y,
	input  wire coord_t ctrl2_x,
	input  wire coord_t ctrl2_y,
	input  wire coord_t end_x,
	input  wire coord_t end_y,
	output logic       out_valid,
	input  wire logic  out_ready,
	output coord_t     box_left,
	output coord_t     box_top,
	output logic [CW-1:0] box_width,
	output logic [CW-1:0] box_height
);

	logic [NS:1] vld_q;
	logic [NS:1] ld;
	pts_t  pts_x, pts_y;
	srch_t set_x, set_y, fin_x, fin_y;
	vals_t val_x, val_y;

	// a stage loads when empty or when its contents move on
	always_comb begin
		ld[NS] = !vld_q[NS] || out_ready;
		for (int i = NS - 1; i >= 1; i--) begin
			ld[i] = !vld_q[i] || ld[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[1]) vld_q[1] <= in_valid;
			for (int i = 2; i <= NS; i++) begin
				if (ld[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign in_ready  = ld[1];
	assign out_valid = vld_q[NS];

	assign pts_x = '{p0: start_x, p1: ctrl1_x, p2: ctrl2_x, p3: end_x};
	assign pts_y = '{p0: start_y, p1: ctrl1_y, p2: ctrl2_y, p3: end_y};

	cbb_setup u_setup_x (.clk(clk), .en(ld[3:1]), .pts(pts_x), .srch(set_x));
	cbb_setup u_setup_y (.clk(clk), .en(ld[3:1]), .pts(pts_y), .srch(set_y));

	cbb_search u_search_x (.clk(clk), .en(ld[PF+3:4]), .srch_in(set_x), .srch_out(fin_x));
	cbb_search u_search_y (.clk(clk), .en(ld[PF+3:4]), .srch_in(set_y), .srch_out(fin_y));

	cbb_eval u_eval_x (.clk(clk), .en(ld[PF+7:PF+4]), .srch(fin_x), .vals(val_x));
	cbb_eval u_eval_y (.clk(clk), .en(ld[PF+7:PF+4]), .srch(fin_y), .vals(val_y));

	cbb_range u_range_x (.clk(clk), .en(ld[PF+9:PF+8]), .vals(val_x), .lo(box_left),
		.span(box_width));
	cbb_range u_range_y (.clk(clk), .en(ld[PF+9:PF+8]), .vals(val_y), .lo(box_top),
		.span(box_height));

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> &vld_q)
		else $error("input blocked with an empty stage");

	a_ready_passes: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output drains");

	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NS] && !out_ready |=> vld_q[NS])
		else $error("held result dropped");

endmodule

`default_nettype wire
